[src/two_level_page_table_engine_assert.svh]
// Assertion macros for the checker file of the page table engine.
`ifndef TWO_LEVEL_PAGE_TABLE_ENGINE_ASSERT_SVH
`define TWO_LEVEL_PAGE_TABLE_ENGINE_ASSERT_SVH

// Checked at every edge outside reset.
`define TLPT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// Checked at every edge, reset included.
`define TLPT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/tlpt_pkg.sv]
`timescale 1ns / 1ps
package tlpt_pkg;

	localparam int TLPT_TABLE_SLOTS       = 16;
	localparam int TLPT_DIR_ENTRIES       = 1024;
	localparam int TLPT_DI_W              = 10;
	localparam int TLPT_ENTRIES_PER_TABLE = 1024;
	localparam int TLPT_TI_W              = 10;
	localparam int TLPT_OFS_W             = 12;
	localparam int TLPT_FRAME_W           = 20;
	localparam int TLPT_ENTRY_W           = 32;
	localparam int TLPT_PRESENT_BIT       = 0;

	typedef enum logic [1:0] {
		CMD_MAP   = 2'd0,
		CMD_UNMAP = 2'd1,
		CMD_XLATE = 2'd2
	} tlpt_cmd_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NO_SLOT    = 2'd1,
		ST_NOT_MAPPED = 2'd2
	} tlpt_status_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_DIR,
		S_CLEAR,
		S_PAGE
	} tlpt_state_t;

	typedef struct packed {
		tlpt_cmd_t   cmd;
		logic [31:0] virt_addr;
		logic [31:0] map_addr;
		logic [11:0] flags;
	} tlpt_req_t;

	typedef struct packed {
		logic [31:0]  phys_out;
		tlpt_status_t status;
	} tlpt_rsp_t;

endpackage

[src/two_level_page_table_engine.sv]
`timescale 1ns / 1ps
// Two-level page table engine. A command is transferred when start is high and busy is low;
// its result appears on rsp for exactly one cycle with done high and cannot be held off,
// and a new command may be transferred in that same cycle. Map on a present table, a map
// that finds the pool exhausted, unmap, a translate that finds no table and the unused code
// finish after the directory read; a translate through a present table also reads the entry,
// and a map that allocates a table clears all 1024 of its entries, one per cycle through the
// single write port of the entry memory. After reset the block stays busy while it clears
// the directory memory one entry per cycle.
module two_level_page_table_engine import tlpt_pkg::*; #(
	parameter int TABLE_SLOTS = TLPT_TABLE_SLOTS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  tlpt_req_t req,
	output logic      busy,
	output logic      done,
	output tlpt_rsp_t rsp
);

	localparam int SLOT_W   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CNT_W    = $clog2(TABLE_SLOTS + 1);
	localparam int DIR_W    = SLOT_W + 1;
	localparam int PG_AW    = SLOT_W + TLPT_TI_W;
	localparam int PG_DEPTH = 1 << PG_AW;

	tlpt_state_t            state_q, state_d;
	logic [TLPT_TI_W-1:0]   sweep_q;
	tlpt_req_t              req_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [CNT_W-1:0]       next_slot_q;
	logic                   done_q;
	tlpt_rsp_t              rsp_q;

	logic                   dir_we, dir_re;
	logic [TLPT_DI_W-1:0]   dir_waddr, dir_raddr;
	logic [DIR_W-1:0]       dir_wdata, dir_rdata;
	logic                   pg_we, pg_re;
	logic [PG_AW-1:0]       pg_waddr, pg_raddr;
	logic [TLPT_ENTRY_W-1:0] pg_wdata, pg_rdata;

	logic                   rsp_load, slot_inc;
	tlpt_rsp_t              rsp_d;

	logic                   dir_present, pool_full, sweep_last;
	logic [SLOT_W-1:0]      dir_slot;
	logic [TLPT_TI_W-1:0]   ti;
	logic [TLPT_DI_W-1:0]   di;
	logic [TLPT_ENTRY_W-1:0] entry_val;

	assign dir_present = dir_rdata[DIR_W-1];
	assign dir_slot    = dir_rdata[SLOT_W-1:0];
	assign pool_full   = next_slot_q >= CNT_W'(TABLE_SLOTS);
	assign sweep_last  = &sweep_q;
	assign ti          = req_q.virt_addr[TLPT_OFS_W +: TLPT_TI_W];
	assign di          = req_q.virt_addr[TLPT_OFS_W + TLPT_TI_W +: TLPT_DI_W];
	assign entry_val   = {req_q.map_addr[31 -: TLPT_FRAME_W], req_q.flags};

	tlpt_ram #(.WIDTH(DIR_W), .DEPTH(TLPT_DIR_ENTRIES)) u_dir_ram (
		.clk   (clk),
		.we    (dir_we),
		.waddr (dir_waddr),
		.wdata (dir_wdata),
		.re    (dir_re),
		.raddr (dir_raddr),
		.rdata (dir_rdata)
	);

	tlpt_ram #(.WIDTH(TLPT_ENTRY_W), .DEPTH(PG_DEPTH)) u_page_ram (
		.clk   (clk),
		.we    (pg_we),
		.waddr (pg_waddr),
		.wdata (pg_wdata),
		.re    (pg_re),
		.raddr (pg_raddr),
		.rdata (pg_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				if (sweep_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) state_d = S_DIR;
			end
			S_DIR: begin
				state_d = S_IDLE;
				unique case (req_q.cmd)
					CMD_MAP: begin
						if (!dir_present && !pool_full) state_d = S_CLEAR;
					end
					CMD_XLATE: begin
						if (dir_present) state_d = S_PAGE;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_CLEAR: begin
				if (sweep_last) state_d = S_IDLE;
			end
			S_PAGE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		dir_we    = 1'b0;
		dir_waddr = di;
		dir_wdata = '0;
		dir_re    = 1'b0;
		dir_raddr = req.virt_addr[TLPT_OFS_W + TLPT_TI_W +: TLPT_DI_W];
		pg_we     = 1'b0;
		pg_waddr  = {slot_q, ti};
		pg_wdata  = '0;
		pg_re     = 1'b0;
		pg_raddr  = {dir_slot, ti};
		rsp_load  = 1'b0;
		slot_inc  = 1'b0;
		rsp_d     = '{phys_out: '0, status: ST_OK};
		unique case (state_q)
			S_INIT: begin
				dir_we    = 1'b1;
				dir_waddr = sweep_q;
			end
			S_IDLE: begin
				dir_re = start;
			end
			S_DIR: begin
				unique case (req_q.cmd)
					CMD_MAP: begin
						if (dir_present) begin
							pg_we    = 1'b1;
							pg_waddr = {dir_slot, ti};
							pg_wdata = entry_val;
							rsp_load = 1'b1;
						end else if (pool_full) begin
							rsp_load     = 1'b1;
							rsp_d.status = ST_NO_SLOT;
						end else begin
							dir_we    = 1'b1;
							dir_wdata = {1'b1, next_slot_q[SLOT_W-1:0]};
							slot_inc  = 1'b1;
						end
					end
					CMD_UNMAP: begin
						pg_we    = dir_present;
						pg_waddr = {dir_slot, ti};
						rsp_load = 1'b1;
					end
					CMD_XLATE: begin
						if (dir_present) begin
							pg_re = 1'b1;
						end else begin
							rsp_load     = 1'b1;
							rsp_d.status = ST_NOT_MAPPED;
						end
					end
					default: rsp_load = 1'b1;
				endcase
			end
			S_CLEAR: begin
				// The new entry is written in place of zero when the sweep passes its index.
				pg_we    = 1'b1;
				pg_waddr = {slot_q, sweep_q};
				pg_wdata = (sweep_q == ti) ? entry_val : '0;
				rsp_load = sweep_last;
			end
			S_PAGE: begin
				rsp_load = 1'b1;
				if (pg_rdata[TLPT_PRESENT_BIT]) begin
					rsp_d.phys_out = {pg_rdata[31 -: TLPT_FRAME_W],
						req_q.virt_addr[TLPT_OFS_W-1:0]};
				end else begin
					rsp_d.status = ST_NOT_MAPPED;
				end
			end
			default: rsp_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			sweep_q     <= '0;
			next_slot_q <= '0;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= rsp_load;
			if (state_q == S_INIT || state_q == S_CLEAR) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (slot_inc) begin
				next_slot_q <= next_slot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= req;
		end
		if (state_q == S_DIR) begin
			slot_q <= next_slot_q[SLOT_W-1:0];
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

[src/tlpt_ram.sv]
`timescale 1ns / 1ps
module tlpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/tlpt_checker.sv]
`timescale 1ns / 1ps
`include "two_level_page_table_engine_assert.svh"
module tlpt_checker import tlpt_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input tlpt_req_t req,
	input logic      busy,
	input logic      done,
	input tlpt_rsp_t rsp
);

	// In the cycle after a command transfer the block is busy and shows no result.
	`TLPT_ASSERT(a_busy_after_transfer, (start && !busy) |=> (busy && !done), "busy or done wrong after a command transfer")
	// A result only ends a busy period and leaves the block ready for the next command.
	`TLPT_ASSERT(a_done_ends_busy, done |-> (!busy && $past(busy)), "result not at the end of a busy period")
	// Failed commands return a zero address.
	`TLPT_ASSERT(a_fail_zero, (done && rsp.status != ST_OK) |-> (rsp.phys_out == '0), "failed command returned an address")
	// No result is shown while reset is applied.
	`TLPT_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !done, "result strobe during reset")

endmodule

bind two_level_page_table_engine tlpt_checker u_tlpt_checker (.*);

[test/tb.sv]
`timescale 1ns / 1ps
module tb;
	import tlpt_pkg::*;

	// The package gives no name to the fourth command code; the block ignores it.
	localparam tlpt_cmd_t CMD_SPARE = tlpt_cmd_t'(2'd3);

	// Directories allocated by the directed part, in pool order. The random part aims at these.
	localparam bit [9:0] ALLOC_DIRS [16] = '{
		10'h000, 10'h3FF, 10'h001, 10'h002, 10'h004, 10'h008, 10'h010, 10'h020,
		10'h040, 10'h080, 10'h100, 10'h200, 10'h155, 10'h2AA, 10'h3F0, 10'h00F
	};
	localparam bit [9:0] HOT_PAGES [8] = '{
		10'h000, 10'h3FF, 10'h155, 10'h2AA, 10'h001, 10'h002, 10'h200, 10'h0F0
	};
	localparam bit [9:0] SPARE_DIR = 10'h300;

	typedef struct {
		tlpt_req_t req;
		bit        typed;
		tlpt_rsp_t rsp;
	} cmd_row_t;

	logic      clk;
	logic      arst_n;
	logic      start;
	tlpt_req_t req;
	logic      busy;
	logic      done;
	tlpt_rsp_t rsp;

	// Expectation that travels with the command currently offered.
	bit        row_typed;
	tlpt_rsp_t row_rsp;
	bit        xfer_seen;
	int        error_count;

	tlpt_rsp_t   expected_rsp_q [$];
	cmd_row_t    directed_rows [$];

	// Shadow copy of the page tables.
	bit          dir_valid [TLPT_DIR_ENTRIES];
	int unsigned dir_slot [TLPT_DIR_ENTRIES];
	logic [31:0] entry_mem [TLPT_TABLE_SLOTS * TLPT_ENTRIES_PER_TABLE];
	int unsigned tables_used;

	two_level_page_table_engine DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic tlpt_rsp_t walk_page_table(tlpt_req_t r);
		logic [9:0]  di;
		logic [9:0]  ti;
		logic [31:0] pte;
		tlpt_rsp_t   res;
		di = r.virt_addr[31:22];
		ti = r.virt_addr[21:12];
		res.phys_out = '0;
		res.status = ST_OK;
		case (r.cmd)
			CMD_MAP: begin
				if (!dir_valid[di] && tables_used >= TLPT_TABLE_SLOTS) begin
					res.status = ST_NO_SLOT;
				end else begin
					if (!dir_valid[di]) begin
						for (int k = 0; k < TLPT_ENTRIES_PER_TABLE; k++)
							entry_mem[tables_used * TLPT_ENTRIES_PER_TABLE + k] = '0;
						dir_valid[di] = 1'b1;
						dir_slot[di] = tables_used;
						tables_used++;
					end
					entry_mem[dir_slot[di] * TLPT_ENTRIES_PER_TABLE + ti] =
						{r.map_addr[31:12], r.flags};
				end
			end
			CMD_UNMAP: begin
				if (dir_valid[di])
					entry_mem[dir_slot[di] * TLPT_ENTRIES_PER_TABLE + ti] = '0;
			end
			CMD_XLATE: begin
				if (!dir_valid[di]) begin
					res.status = ST_NOT_MAPPED;
				end else begin
					pte = entry_mem[dir_slot[di] * TLPT_ENTRIES_PER_TABLE + ti];
					if (!pte[TLPT_PRESENT_BIT])
						res.status = ST_NOT_MAPPED;
					else
						res.phys_out = {pte[31:12], r.virt_addr[11:0]};
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// Results are checked before a new transfer is recorded; a command never sees its own
	// result at the edge that takes it.
	always @(posedge clk) begin : monitor
		tlpt_rsp_t want;
		tlpt_rsp_t model;
		xfer_seen = 1'b0;
		if (arst_n) begin
			if (done) begin
				if (expected_rsp_q.size() == 0) begin
					$error("result with no command outstanding: phys_out %h status %0d",
						rsp.phys_out, rsp.status);
					error_count++;
				end else begin
					want = expected_rsp_q.pop_front();
					if (rsp.phys_out !== want.phys_out) begin
						$error("phys_out: expected %h, got %h", want.phys_out, rsp.phys_out);
						error_count++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						error_count++;
					end
				end
			end
			if (start && !busy) begin
				xfer_seen = 1'b1;
				model = walk_page_table(req);
				expected_rsp_q.push_back(row_typed ? row_rsp : model);
			end
		end
	end

	function automatic cmd_row_t mk_row(tlpt_cmd_t cmd, logic [31:0] va, logic [31:0] pa,
			logic [11:0] fl, bit typed, logic [31:0] phys, tlpt_status_t st);
		cmd_row_t row;
		row.req.cmd = cmd;
		row.req.virt_addr = va;
		row.req.map_addr = pa;
		row.req.flags = fl;
		row.typed = typed;
		row.rsp.phys_out = phys;
		row.rsp.status = st;
		return row;
	endfunction

	// Called at a falling edge; returns at a falling edge after the transfer.
	task automatic send(tlpt_req_t r, bit typed, tlpt_rsp_t exp_rsp, int idle_pct);
		req = r;
		row_typed = typed;
		row_rsp = exp_rsp;
		start = 1'b1;
		do @(negedge clk); while (!xfer_seen);
		if ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
	endtask

	task automatic drain;
		start = 1'b0;
		while (expected_rsp_q.size() != 0) @(negedge clk);
	endtask

	task automatic run_random(int count, int idle_pct);
		tlpt_req_t  r;
		int         pick;
		logic [9:0] dir_idx;
		logic [9:0] page_idx;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 6) begin
				r.cmd = tlpt_cmd_t'($urandom_range(3));
				r.virt_addr = $urandom;
				r.map_addr = $urandom;
				r.flags = 12'($urandom);
			end else begin
				pick = $urandom_range(99);
				r.cmd = (pick < 35) ? CMD_MAP : (pick < 50) ? CMD_UNMAP : CMD_XLATE;
				dir_idx = ($urandom_range(9) == 0) ? 10'($urandom)
					: ALLOC_DIRS[$urandom_range(15)];
				page_idx = ($urandom_range(7) == 0) ? 10'($urandom)
					: HOT_PAGES[$urandom_range(7)];
				r.virt_addr = {dir_idx, page_idx, 12'($urandom)};
				r.map_addr = $urandom;
				r.flags = {11'($urandom), 1'($urandom_range(99) < 85)};
			end
			send(r, 1'b0, '0, idle_pct);
		end
	endtask

	initial begin
		error_count = 0;
		tables_used = 0;
		start = 1'b0;
		req = '0;
		row_typed = 1'b0;
		row_rsp = '0;
		xfer_seen = 1'b0;
		arst_n = 1'b0;

		directed_rows.push_back(mk_row(CMD_XLATE, 32'h0000_0000, 32'h0, 12'h000,
			1'b1, 32'h0, ST_NOT_MAPPED));
		// Unmap with no table behind the directory entry still succeeds.
		directed_rows.push_back(mk_row(CMD_UNMAP, 32'hFFFF_FFFF, 32'h0, 12'h000,
			1'b1, 32'h0, ST_OK));
		directed_rows.push_back(mk_row(CMD_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF,
			1'b1, 32'h0, ST_OK));
		directed_rows.push_back(mk_row(CMD_MAP, 32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF,
			1'b1, 32'h0, ST_OK));
		directed_rows.push_back(mk_row(CMD_XLATE, 32'h0000_0FFF, 32'h0, 12'h000,
			1'b1, 32'hFFFF_FFFF, ST_OK));
		directed_rows.push_back(mk_row(CMD_MAP, 32'hFFFF_FFFF, 32'h0000_0000, 12'h001,
			1'b1, 32'h0, ST_OK));
		directed_rows.push_back(mk_row(CMD_XLATE, 32'hFFFF_FFFF, 32'h0, 12'h000,
			1'b1, 32'h0000_0FFF, ST_OK));
		// An entry written without the present flag must not translate.
		directed_rows.push_back(mk_row(CMD_MAP, 32'hFFC0_0000, 32'h1234_5678, 12'hFFE,
			1'b1, 32'h0, ST_OK));
		directed_rows.push_back(mk_row(CMD_XLATE, 32'hFFC0_0ABC, 32'h0, 12'h000,
			1'b1, 32'h0, ST_NOT_MAPPED));
		// The table exists but this entry was cleared on allocation.
		directed_rows.push_back(mk_row(CMD_XLATE, 32'h0000_1000, 32'h0, 12'h000,
			1'b1, 32'h0, ST_NOT_MAPPED));
		directed_rows.push_back(mk_row(CMD_UNMAP, 32'h0000_0123, 32'h0, 12'h000,
			1'b1, 32'h0, ST_OK));
		// Fill the rest of the pool, then one more directory entry finds no table left.
		for (int i = 2; i < TLPT_TABLE_SLOTS; i++)
			directed_rows.push_back(mk_row(CMD_MAP, {ALLOC_DIRS[i], 10'(i * 37), 12'h0},
				32'h0001_1000 * i, 12'(i * 16 + 1), 1'b0, 32'h0, ST_OK));
		directed_rows.push_back(mk_row(CMD_MAP, {SPARE_DIR, 10'h155, 12'h0},
			32'hDEAD_B000, 12'h001, 1'b1, 32'h0, ST_NO_SLOT));

		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp, 30);
		drain();

		run_random(650, 30);
		drain();
		run_random(650, 62);
		drain();
		run_random(600, 0);
		drain();
		repeat (20) @(negedge clk);

		if (error_count == 0 && expected_rsp_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

[filelist.f]
+incdir+src
src/tlpt_pkg.sv
src/tlpt_ram.sv
src/two_level_page_table_engine.sv
src/tlpt_checker.sv
test/tb.sv
